@@ hdl/length_prefixed_message_parser_unit_macros.svh @@
// Assertion macros for the length prefixed message parser.
// Used by the top level; expects clk and rst_n in the enclosing scope.
`ifndef LENGTH_PREFIXED_MESSAGE_PARSER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lpmp_pkg.sv @@
// Package for the length prefixed message parser.
// Holds the parse phase and status codes, register indexes and reset values.
`default_nettype none
package lpmp_pkg;

  typedef enum logic [3:0] {
    PH_VER      = 4'd0,
    PH_KIND     = 4'd1,
    PH_TS       = 4'd2,
    PH_SIDLEN   = 4'd3,
    PH_SID      = 4'd4,
    PH_UUIDLEN  = 4'd5,
    PH_UUID     = 4'd6,
    PH_TITLELEN = 4'd7,
    PH_TITLE    = 4'd8,
    PH_MCOUNT   = 4'd9,
    PH_MLEN     = 4'd10,
    PH_MEMBER   = 4'd11,
    PH_TLEN     = 4'd12,
    PH_TEXT     = 4'd13,
    PH_DONE     = 4'd14,
    PH_ERR      = 4'd15
  } phase_t;

  typedef enum logic [2:0] {
    ST_PENDING = 3'd0,
    ST_OK      = 3'd1,
    ST_TRUNC   = 3'd2,
    ST_BADVER  = 3'd3,
    ST_SENDER  = 3'd4,
    ST_UUID    = 3'd5,
    ST_KIND    = 3'd6
  } status_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_KIND_DIRECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND_INVITE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND_GTEXT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SENDER_CAP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UUID_CAP    = 3'd4;

  localparam logic [7:0]  RST_KIND_DIRECT = 8'd0;
  localparam logic [7:0]  RST_KIND_INVITE = 8'd1;
  localparam logic [7:0]  RST_KIND_GTEXT  = 8'd2;
  localparam logic [16:0] RST_SENDER_CAP  = 17'd91;
  localparam logic [8:0]  RST_UUID_CAP    = 9'd64;

  localparam logic [7:0] VER_ONE = 8'd1;
  localparam logic [7:0] VER_TWO = 8'd2;

endpackage
`default_nettype wire

@@ hdl/length_prefixed_message_parser_unit.sv @@
// Length prefixed message parser: tags each message byte with its field.
// Depends on lpmp_pkg and length_prefixed_message_parser_unit_macros.svh.
//
// Usage:
// The input channel (in_valid, in_stall) takes one message byte per request,
// with in_end_of_message on the final byte of a message. The output channel
// (out_valid, out_stall) returns one tagged request for each input request,
// in order, carrying the byte, its field tag, member index, kind, version
// and status. The user must write configuration registers (cfg_we, cfg_index,
// cfg_wdata) only while no message is in flight; the block does not check.
// out_valid rises in the cycle after a byte is accepted, and one byte is
// taken every cycle while in_stall is low; the phase and counter update
// for each byte is computed combinationally from the parser state.
// Reset loads the register defaults, returns the parser to the version byte
// and empties the output register. While the receiver stalls a full output
// register, it holds its request and in_stall is raised in the same cycle.
// Parser state returns to its reset value after every final byte.
`default_nettype none
`include "length_prefixed_message_parser_unit_macros.svh"
module length_prefixed_message_parser_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       in_data_byte,
  input  wire logic                             in_end_of_message,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            out_byte_out,
  output logic [3:0]                            out_field_tag,
  output logic [15:0]                           out_member_index,
  output logic [7:0]                            out_message_kind,
  output logic [1:0]                            out_format_version,
  output logic [2:0]                            out_status,
  output logic                                  out_last_of_message,
  input  wire logic                             cfg_we,
  input  wire logic [lpmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lpmp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [7:0]  kind_direct_r, kind_invite_r, kind_gtext_r;
  logic [16:0] sender_cap_r;
  logic [8:0]  uuid_cap_r;

  lpmp_pkg::phase_t  phase_r, phase_nxt;
  lpmp_pkg::status_t err_r, err_nxt, status_val;
  logic [1:0]  pos_r, pos_nxt;
  logic [31:0] acc_r, acc_nxt, acc_sh;
  logic [31:0] rem_r, rem_nxt, rem_dec;
  logic [15:0] mem_r, mem_nxt, mem_dec;
  logic [15:0] cur_r, cur_nxt;
  logic [1:0]  ver_r, ver_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic        inv_r, inv_nxt;
  logic [15:0] idx_val;
  logic [1:0]  ver_out;
  logic [7:0]  kind_res;

  logic in_acc;
  logic out_valid_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_direct_r <= lpmp_pkg::RST_KIND_DIRECT;
      kind_invite_r <= lpmp_pkg::RST_KIND_INVITE;
      kind_gtext_r  <= lpmp_pkg::RST_KIND_GTEXT;
      sender_cap_r  <= lpmp_pkg::RST_SENDER_CAP;
      uuid_cap_r    <= lpmp_pkg::RST_UUID_CAP;
    end else if (cfg_we) begin
      case (cfg_index)
        lpmp_pkg::CFG_KIND_DIRECT: kind_direct_r <= cfg_wdata[7:0];
        lpmp_pkg::CFG_KIND_INVITE: kind_invite_r <= cfg_wdata[7:0];
        lpmp_pkg::CFG_KIND_GTEXT:  kind_gtext_r  <= cfg_wdata[7:0];
        lpmp_pkg::CFG_SENDER_CAP:  sender_cap_r  <= cfg_wdata[16:0];
        lpmp_pkg::CFG_UUID_CAP:    uuid_cap_r    <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    mem_nxt   = mem_r;
    cur_nxt   = cur_r;
    ver_nxt   = ver_r;
    kind_nxt  = kind_r;
    err_nxt   = err_r;
    inv_nxt   = inv_r;
    acc_sh    = {acc_r[23:0], in_data_byte};
    rem_dec   = rem_r - 32'd1;
    mem_dec   = mem_r - 16'd1;
    idx_val   = (phase_r == lpmp_pkg::PH_MLEN || phase_r == lpmp_pkg::PH_MEMBER)
                ? cur_r : 16'd0;

    case (phase_r)
      lpmp_pkg::PH_VER: begin
        if (in_data_byte == lpmp_pkg::VER_ONE) begin
          ver_nxt   = 2'd1;
          kind_nxt  = kind_direct_r;
          phase_nxt = lpmp_pkg::PH_TS;
        end else if (in_data_byte == lpmp_pkg::VER_TWO) begin
          ver_nxt   = 2'd2;
          phase_nxt = lpmp_pkg::PH_KIND;
        end else begin
          err_nxt   = lpmp_pkg::ST_BADVER;
          phase_nxt = lpmp_pkg::PH_ERR;
        end
      end
      lpmp_pkg::PH_KIND: begin
        kind_nxt  = in_data_byte;
        phase_nxt = lpmp_pkg::PH_TS;
      end
      lpmp_pkg::PH_TS: begin
        acc_nxt = acc_sh;
        pos_nxt = pos_r + 2'd1;
        if (pos_r >= 2'd3) begin
          pos_nxt   = 2'd0;
          acc_nxt   = 32'd0;
          phase_nxt = lpmp_pkg::PH_SIDLEN;
        end
      end
      lpmp_pkg::PH_SIDLEN, lpmp_pkg::PH_SID: begin
        if (phase_r == lpmp_pkg::PH_SIDLEN) begin
          acc_nxt = acc_sh;
          pos_nxt = pos_r + 2'd1;
          rem_nxt = rem_r;
        end else begin
          rem_nxt = rem_dec;
        end
        if (phase_r == lpmp_pkg::PH_SIDLEN && pos_r >= 2'd1
            && acc_sh >= {15'd0, sender_cap_r}) begin
          pos_nxt   = 2'd0;
          err_nxt   = lpmp_pkg::ST_SENDER;
          phase_nxt = lpmp_pkg::PH_ERR;
        end else if (phase_r == lpmp_pkg::PH_SIDLEN && pos_r >= 2'd1
                     && acc_sh != 32'd0) begin
          pos_nxt   = 2'd0;
          rem_nxt   = acc_sh;
          acc_nxt   = 32'd0;
          phase_nxt = lpmp_pkg::PH_SID;
        end else if ((phase_r == lpmp_pkg::PH_SIDLEN && pos_r >= 2'd1)
                     || (phase_r == lpmp_pkg::PH_SID && rem_dec == 32'd0)) begin
          if (phase_r == lpmp_pkg::PH_SIDLEN) begin
            pos_nxt = 2'd0;
            rem_nxt = 32'd0;
            acc_nxt = 32'd0;
          end
          if (ver_r == 2'd1 || kind_r == kind_direct_r) begin
            phase_nxt = lpmp_pkg::PH_TLEN;
          end else if (kind_r == kind_invite_r) begin
            inv_nxt   = 1'b1;
            phase_nxt = lpmp_pkg::PH_UUIDLEN;
          end else if (kind_r == kind_gtext_r) begin
            inv_nxt   = 1'b0;
            phase_nxt = lpmp_pkg::PH_UUIDLEN;
          end else begin
            err_nxt   = lpmp_pkg::ST_KIND;
            phase_nxt = lpmp_pkg::PH_ERR;
          end
        end
      end
      lpmp_pkg::PH_UUIDLEN: begin
        if ({1'b0, in_data_byte} >= uuid_cap_r) begin
          err_nxt   = lpmp_pkg::ST_UUID;
          phase_nxt = lpmp_pkg::PH_ERR;
        end else begin
          rem_nxt = {24'd0, in_data_byte};
          acc_nxt = 32'd0;
          if (in_data_byte != 8'd0) begin
            phase_nxt = lpmp_pkg::PH_UUID;
          end else begin
            phase_nxt = inv_r ? lpmp_pkg::PH_TITLELEN : lpmp_pkg::PH_TLEN;
          end
        end
      end
      lpmp_pkg::PH_UUID: begin
        rem_nxt = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_nxt = inv_r ? lpmp_pkg::PH_TITLELEN : lpmp_pkg::PH_TLEN;
        end
      end
      lpmp_pkg::PH_TITLELEN: begin
        acc_nxt = acc_sh;
        pos_nxt = pos_r + 2'd1;
        if (pos_r >= 2'd1) begin
          pos_nxt   = 2'd0;
          rem_nxt   = acc_sh;
          acc_nxt   = 32'd0;
          phase_nxt = (acc_sh != 32'd0) ? lpmp_pkg::PH_TITLE : lpmp_pkg::PH_MCOUNT;
        end
      end
      lpmp_pkg::PH_TITLE: begin
        rem_nxt = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_nxt = lpmp_pkg::PH_MCOUNT;
        end
      end
      lpmp_pkg::PH_MCOUNT: begin
        acc_nxt = acc_sh;
        pos_nxt = pos_r + 2'd1;
        if (pos_r >= 2'd1) begin
          pos_nxt   = 2'd0;
          mem_nxt   = acc_sh[15:0];
          acc_nxt   = 32'd0;
          cur_nxt   = 16'd0;
          phase_nxt = (acc_sh[15:0] == 16'd0) ? lpmp_pkg::PH_DONE : lpmp_pkg::PH_MLEN;
        end
      end
      lpmp_pkg::PH_MLEN: begin
        acc_nxt = acc_sh;
        pos_nxt = pos_r + 2'd1;
        if (pos_r >= 2'd1) begin
          pos_nxt = 2'd0;
          rem_nxt = acc_sh;
          acc_nxt = 32'd0;
          if (acc_sh != 32'd0) begin
            phase_nxt = lpmp_pkg::PH_MEMBER;
          end else begin
            mem_nxt   = mem_dec;
            cur_nxt   = cur_r + 16'd1;
            phase_nxt = (mem_dec == 16'd0) ? lpmp_pkg::PH_DONE : lpmp_pkg::PH_MLEN;
          end
        end
      end
      lpmp_pkg::PH_MEMBER: begin
        rem_nxt = rem_dec;
        if (rem_dec == 32'd0) begin
          mem_nxt   = mem_dec;
          cur_nxt   = cur_r + 16'd1;
          phase_nxt = (mem_dec == 16'd0) ? lpmp_pkg::PH_DONE : lpmp_pkg::PH_MLEN;
        end
      end
      lpmp_pkg::PH_TLEN: begin
        acc_nxt = acc_sh;
        pos_nxt = pos_r + 2'd1;
        if (pos_r >= 2'd3) begin
          pos_nxt   = 2'd0;
          rem_nxt   = acc_sh;
          acc_nxt   = 32'd0;
          phase_nxt = (acc_sh != 32'd0) ? lpmp_pkg::PH_TEXT : lpmp_pkg::PH_DONE;
        end
      end
      lpmp_pkg::PH_TEXT: begin
        rem_nxt = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_nxt = lpmp_pkg::PH_DONE;
        end
      end
      default: ;
    endcase

    if (err_nxt != lpmp_pkg::ST_PENDING) begin
      status_val = err_nxt;
    end else if (phase_nxt == lpmp_pkg::PH_DONE) begin
      status_val = lpmp_pkg::ST_OK;
    end else if (in_end_of_message) begin
      status_val = lpmp_pkg::ST_TRUNC;
    end else begin
      status_val = lpmp_pkg::ST_PENDING;
    end
    ver_out  = ver_nxt;
    kind_res = kind_nxt;

    if (in_end_of_message) begin
      phase_nxt = lpmp_pkg::PH_VER;
      pos_nxt   = 2'd0;
      acc_nxt   = 32'd0;
      rem_nxt   = 32'd0;
      mem_nxt   = 16'd0;
      cur_nxt   = 16'd0;
      ver_nxt   = 2'd0;
      kind_nxt  = 8'd0;
      err_nxt   = lpmp_pkg::ST_PENDING;
      inv_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lpmp_pkg::PH_VER;
      pos_r       <= 2'd0;
      acc_r       <= 32'd0;
      rem_r       <= 32'd0;
      mem_r       <= 16'd0;
      cur_r       <= 16'd0;
      ver_r       <= 2'd0;
      kind_r      <= 8'd0;
      err_r       <= lpmp_pkg::ST_PENDING;
      inv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        acc_r   <= acc_nxt;
        rem_r   <= rem_nxt;
        mem_r   <= mem_nxt;
        cur_r   <= cur_nxt;
        ver_r   <= ver_nxt;
        kind_r  <= kind_nxt;
        err_r   <= err_nxt;
        inv_r   <= inv_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_byte_out        <= in_data_byte;
      out_field_tag       <= 4'(phase_r);
      out_member_index    <= idx_val;
      out_message_kind    <= kind_res;
      out_format_version  <= ver_out;
      out_status          <= 3'(status_val);
      out_last_of_message <= in_end_of_message;
    end
  end

  `LPMP_ASSERT_NEXT(a_clear_after_last, in_acc && in_end_of_message, phase_r == lpmp_pkg::PH_VER && err_r == lpmp_pkg::ST_PENDING && ver_r == 2'd0, "parser state not cleared after final byte")
  `LPMP_ASSERT_NOW(a_err_has_cause, phase_r == lpmp_pkg::PH_ERR, err_r != lpmp_pkg::ST_PENDING, "error phase without an error cause")
  `LPMP_ASSERT_NOW(a_members_left, phase_r == lpmp_pkg::PH_MLEN || phase_r == lpmp_pkg::PH_MEMBER, mem_r != 16'd0, "member phase with no members left")
  `LPMP_ASSERT_NEXT(a_out_after_accept, in_acc, out_valid_r, "accepted byte produced no output request")

endmodule
`default_nettype wire
